### rtl/pxb_pkg.sv
// Shared widths and blend mode codes for the pixel layer blend block.
package pxb_pkg;

   // Field widths of one transfer on each channel.
   localparam int unsigned OP_WIDTH    = 4;
   localparam int unsigned PIXEL_WIDTH = 8;

   // Blend mode codes; the remaining codes of the field produce zero.
   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD = 4'd0,
      OP_SUB = 4'd1,
      OP_AVG = 4'd2,
      OP_MUL = 4'd3,
      OP_MIN = 4'd4,
      OP_MAX = 4'd5,
      OP_AMP = 4'd6,
      OP_AND = 4'd7,
      OP_OR  = 4'd8,
      OP_XOR = 4'd9
   } pxb_op_type;

endpackage

### rtl/pxb_if.sv
// Valid/ready stream interfaces for the blend request and response channels.
interface pxb_req_if
   import pxb_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [OP_WIDTH-1:0]    operation;
   logic [PIXEL_WIDTH-1:0] base_value;
   logic [PIXEL_WIDTH-1:0] layer_value;

   modport source (output valid, output operation, output base_value,
                   output layer_value, input ready);
   modport sink   (input valid, input operation, input base_value,
                   input layer_value, output ready);
endinterface

interface pxb_rsp_if
   import pxb_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic [PIXEL_WIDTH-1:0] blended_value;

   modport source (output valid, output blended_value, input ready);
   modport sink   (input valid, input blended_value, output ready);
endinterface

### rtl/pixel_layer_blend.sv
// Pixel layer blend: combines one 8-bit base channel with one 8-bit layer channel.
//
// The block takes one request transfer per clock while any stage has room, and
// returns one response per request, in order. The four register stages are:
// products, arithmetic and logic results with the square sum, the upper four root
// bits of the amplitude square root, and the lower four root bits with the final
// mode select into the output register. Every stage holds its item while the stage
// after it is full and stalled, so a new request is still taken whenever any stage
// has room. Mode codes 10 to 15 give zero.
module pixel_layer_blend
   import pxb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   pxb_req_if.sink   req_chan,
   pxb_rsp_if.source rsp_chan
);

   // Partial square root state: remainder and root bits found so far.
   typedef struct packed {
      logic [PIXEL_WIDTH+1:0] rem;
      logic [PIXEL_WIDTH-1:0] root;
   } sqrt_state_type;

   // One digit of the restoring square root: brings in two radicand bits.
   function automatic sqrt_state_type sqrt_step(sqrt_state_type cur, logic [1:0] pair);
      logic [PIXEL_WIDTH+3:0] acc;
      logic [PIXEL_WIDTH+3:0] trial;
      sqrt_state_type         nxt;
      acc   = {cur.rem, pair};
      trial = {2'b00, cur.root, 2'b01};
      if (acc >= trial) begin
         nxt.rem  = (PIXEL_WIDTH+2)'(acc - trial);
         nxt.root = {cur.root[PIXEL_WIDTH-2:0], 1'b1};
      end else begin
         nxt.rem  = acc[PIXEL_WIDTH+1:0];
         nxt.root = {cur.root[PIXEL_WIDTH-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Stage valid bits and load enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic load1, load2, load3, load4;

   assign load4 = !v4_ff || rsp_chan.ready;
   assign load3 = !v3_ff || load4;
   assign load2 = !v2_ff || load3;
   assign load1 = !v1_ff || load2;
   assign req_chan.ready = load1;

   // Stage one payload.
   logic [OP_WIDTH-1:0]      op1_ff;
   logic [PIXEL_WIDTH-1:0]   a1_ff, b1_ff;
   logic [2*PIXEL_WIDTH-1:0] aa1_ff, bb1_ff, ab1_ff;

   // Stage two payload.
   logic [OP_WIDTH-1:0]      op2_ff;
   logic [PIXEL_WIDTH-1:0]   pre2_ff;
   logic [2*PIXEL_WIDTH-1:0] sq2_ff;

   // Stage three payload.
   logic [OP_WIDTH-1:0]      op3_ff;
   logic [PIXEL_WIDTH-1:0]   pre3_ff;
   logic [PIXEL_WIDTH-1:0]   sqlo3_ff;
   sqrt_state_type           sr3_ff;

   // Stage four payload is the response register.
   logic [PIXEL_WIDTH-1:0]   out4_ff;

   // Stage two logic: arithmetic and bitwise modes, plus the halved square sum.
   logic [PIXEL_WIDTH:0]     sum_in;
   logic [2*PIXEL_WIDTH:0]   mulq_in;
   logic [2*PIXEL_WIDTH:0]   sqsum_in;
   logic [PIXEL_WIDTH-1:0]   quot_in;
   logic [PIXEL_WIDTH-1:0]   pre2_in;

   always_comb begin
      sum_in   = {1'b0, a1_ff} + {1'b0, b1_ff};
      // Division by 255 through the reciprocal identity, truncating.
      mulq_in  = {1'b0, ab1_ff} + {{(PIXEL_WIDTH+1){1'b0}}, ab1_ff[2*PIXEL_WIDTH-1:PIXEL_WIDTH]}
                 + (2*PIXEL_WIDTH+1)'(1);
      quot_in  = mulq_in[2*PIXEL_WIDTH-1:PIXEL_WIDTH];
      sqsum_in = {1'b0, aa1_ff} + {1'b0, bb1_ff};
      case (op1_ff)
         OP_ADD:  pre2_in = sum_in[PIXEL_WIDTH] ? '1 : sum_in[PIXEL_WIDTH-1:0];
         OP_SUB:  pre2_in = (a1_ff > b1_ff) ? PIXEL_WIDTH'(a1_ff - b1_ff) : '0;
         OP_AVG:  pre2_in = sum_in[PIXEL_WIDTH:1];
         OP_MUL:  pre2_in = quot_in;
         OP_MIN:  pre2_in = (a1_ff < b1_ff) ? a1_ff : b1_ff;
         OP_MAX:  pre2_in = (a1_ff > b1_ff) ? a1_ff : b1_ff;
         OP_AND:  pre2_in = a1_ff & b1_ff;
         OP_OR:   pre2_in = a1_ff | b1_ff;
         OP_XOR:  pre2_in = a1_ff ^ b1_ff;
         default: pre2_in = '0;
      endcase
   end

   // Stage three logic: upper four root digits.
   sqrt_state_type sr3_in;

   always_comb begin
      sr3_in = '0;
      for (int i = 0; i < PIXEL_WIDTH / 2; i++) begin
         sr3_in = sqrt_step(sr3_in, sq2_ff[2*PIXEL_WIDTH-1-2*i -: 2]);
      end
   end

   // Stage four logic: lower four root digits and the final mode select.
   sqrt_state_type         sr4_in;
   logic [PIXEL_WIDTH-1:0] out4_in;

   always_comb begin
      sr4_in = sr3_ff;
      for (int i = 0; i < PIXEL_WIDTH / 2; i++) begin
         sr4_in = sqrt_step(sr4_in, sqlo3_ff[PIXEL_WIDTH-1-2*i -: 2]);
      end
      out4_in = (op3_ff == OP_AMP) ? sr4_in.root : pre3_ff;
   end

   // Valid bits advance with their stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (load1) v1_ff <= req_chan.valid;
         if (load2) v2_ff <= v1_ff;
         if (load3) v3_ff <= v2_ff;
         if (load4) v4_ff <= v3_ff;
      end
   end

   // Payload registers; a stage loads only when it is empty or can pass its item on.
   always_ff @(posedge clock) begin
      if (load1) begin
         op1_ff <= req_chan.operation;
         a1_ff  <= req_chan.base_value;
         b1_ff  <= req_chan.layer_value;
         aa1_ff <= (2*PIXEL_WIDTH)'(req_chan.base_value)
                   * (2*PIXEL_WIDTH)'(req_chan.base_value);
         bb1_ff <= (2*PIXEL_WIDTH)'(req_chan.layer_value)
                   * (2*PIXEL_WIDTH)'(req_chan.layer_value);
         ab1_ff <= (2*PIXEL_WIDTH)'(req_chan.base_value)
                   * (2*PIXEL_WIDTH)'(req_chan.layer_value);
      end
      if (load2) begin
         op2_ff  <= op1_ff;
         pre2_ff <= pre2_in;
         sq2_ff  <= sqsum_in[2*PIXEL_WIDTH:1];
      end
      if (load3) begin
         op3_ff   <= op2_ff;
         pre3_ff  <= pre2_ff;
         sqlo3_ff <= sq2_ff[PIXEL_WIDTH-1:0];
         sr3_ff   <= sr3_in;
      end
      if (load4) begin
         out4_ff <= out4_in;
      end
   end

   assign rsp_chan.valid         = v4_ff;
   assign rsp_chan.blended_value = out4_ff;

   // An accepted request always occupies the first stage on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> v1_ff)
      else $error("accepted request did not enter the first stage");

   // The block only refuses requests when every stage holds an item.
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("request refused while the pipeline has room");

   // The reciprocal quotient matches a true division by 255.
   assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> ((16'(quot_in) * 16'd255 <= ab1_ff)
                 && (ab1_ff - 16'(quot_in) * 16'd255 < 16'd255)))
      else $error("multiply quotient is not floor of product over 255");

   // The partial square root remainder never exceeds twice the partial root.
   assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (sr3_ff.rem <= (PIXEL_WIDTH+2)'({sr3_ff.root, 1'b0})))
      else $error("square root remainder out of range");

endmodule

### test/pixel_layer_blend_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the pixel layer blend block.
module pixel_layer_blend_test;
   import pxb_pkg::*;

   localparam int PIPE_DEPTH       = 4;
   localparam int WATCHDOG_LIMIT   = 1000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int N_DIRECTED       = 25;
   localparam int N_PHASES         = 4;
   localparam int PHASE_ITEMS      = 400;
   localparam int PRESSURE_ITEMS   = 200;

   // Mode codes that the package leaves unnamed; all of them blend to zero.
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_LO = 4'd10;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED_HI = 4'd15;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;

   // One directed request; a literal result is given only where it is obvious.
   typedef struct {
      logic [OP_WIDTH-1:0] operation;
      pixel_type           base_value;
      pixel_type           layer_value;
      bit                  literal_en;
      pixel_type           literal_value;
   } blend_row_type;

   blend_row_type directed_rows [N_DIRECTED] = '{
      '{OP_ADD,       8'd0,   8'd0,   1'b1, 8'd0},
      '{OP_ADD,       8'd255, 8'd255, 1'b1, 8'd255},
      '{OP_ADD,       8'd200, 8'd56,  1'b1, 8'd255},
      '{OP_ADD,       8'd100, 8'd27,  1'b0, 8'd0},
      '{OP_SUB,       8'd0,   8'd255, 1'b1, 8'd0},
      '{OP_SUB,       8'd255, 8'd0,   1'b1, 8'd255},
      '{OP_SUB,       8'd77,  8'd77,  1'b1, 8'd0},
      '{OP_SUB,       8'd200, 8'd13,  1'b0, 8'd0},
      '{OP_AVG,       8'd255, 8'd255, 1'b1, 8'd255},
      '{OP_AVG,       8'd255, 8'd0,   1'b0, 8'd0},
      '{OP_MUL,       8'd255, 8'd255, 1'b1, 8'd255},
      '{OP_MUL,       8'd254, 8'd1,   1'b1, 8'd0},
      '{OP_MUL,       8'd128, 8'd2,   1'b0, 8'd0},
      '{OP_MUL,       8'd0,   8'd255, 1'b1, 8'd0},
      '{OP_MIN,       8'd0,   8'd255, 1'b1, 8'd0},
      '{OP_MAX,       8'd0,   8'd255, 1'b1, 8'd255},
      '{OP_AMP,       8'd255, 8'd255, 1'b1, 8'd255},
      '{OP_AMP,       8'd0,   8'd0,   1'b1, 8'd0},
      '{OP_AMP,       8'd255, 8'd0,   1'b0, 8'd0},
      '{OP_AMP,       8'd3,   8'd4,   1'b0, 8'd0},
      '{OP_AND,       8'hF0,  8'h3C,  1'b0, 8'd0},
      '{OP_OR,        8'hAA,  8'h55,  1'b1, 8'd255},
      '{OP_XOR,       8'hFF,  8'hFF,  1'b1, 8'd0},
      '{OP_UNUSED_LO, 8'd255, 8'd255, 1'b1, 8'd0},
      '{OP_UNUSED_HI, 8'd255, 8'd255, 1'b1, 8'd0}
   };

   // Idle percentages per phase: none, sender, receiver, both.
   int sender_phase_pct   [N_PHASES] = '{0, 87, 0, 9};
   int receiver_phase_pct [N_PHASES] = '{0, 0, 87, 9};

   logic clock;
   logic reset;

   pxb_req_if req_chan ();
   pxb_rsp_if rsp_chan ();

   pixel_layer_blend i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pixel_type expected_blends [$];
   bit        literal_en;
   pixel_type literal_value;
   int        sender_idle_pct    = 0;
   int        receiver_stall_pct = 0;
   int        hold_token         = 0;
   int        error_count        = 0;
   int        requests_sent      = 0;
   int        responses_checked  = 0;
   int        quiet_cycles       = 0;
   bit [15:0] modes_seen         = '0;

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Append one expected response at the tail of the queue.
   function automatic void expect_blend(pixel_type value);
      expected_blends.insert(expected_blends.size(), value);
   endfunction

   // Blended channel value for one request.
   function automatic pixel_type blend_predict(logic [OP_WIDTH-1:0] operation, pixel_type a,
                                               pixel_type b);
      logic [8:0]  sum;
      logic [15:0] product;
      logic [16:0] squares;
      logic [15:0] mean_square;
      pixel_type   root;
      pixel_type   trial;
      pixel_type   blended;
      sum     = {1'b0, a} + {1'b0, b};
      product = 16'(a) * 16'(b);
      squares = 17'(a) * 17'(a) + 17'(b) * 17'(b);
      case (operation)
         OP_ADD: begin
            blended = sum[8] ? 8'hFF : sum[7:0];
         end
         OP_SUB: begin
            blended = (a > b) ? a - b : '0;
         end
         OP_AVG: begin
            blended = sum[8:1];
         end
         OP_MUL: begin
            blended = pixel_type'(product / 16'd255);
         end
         OP_MIN: begin
            blended = (a < b) ? a : b;
         end
         OP_MAX: begin
            blended = (a > b) ? a : b;
         end
         OP_AMP: begin
            // Bitwise integer square root of the halved sum of squares.
            mean_square = squares[16:1];
            root = '0;
            for (int i = PIXEL_WIDTH - 1; i >= 0; i--) begin
               trial = root | (pixel_type'(1) << i);
               if (16'(trial) * 16'(trial) <= mean_square) begin
                  root = trial;
               end
            end
            blended = root;
         end
         OP_AND: begin
            blended = a & b;
         end
         OP_OR: begin
            blended = a | b;
         end
         OP_XOR: begin
            blended = a ^ b;
         end
         default: begin
            blended = '0;
         end
      endcase
      return blended;
   endfunction

   // Pixel values lean toward the extremes now and then.
   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return pixel_type'($urandom_range(255));
         end
      endcase
   endfunction

   // Offer one request after random idle cycles and wait for its transfer.
   task automatic send_blend(logic [OP_WIDTH-1:0] operation, pixel_type a, pixel_type b,
                             bit lit_en, pixel_type lit_value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.operation   <= operation;
      req_chan.base_value  <= a;
      req_chan.layer_value <= b;
      literal_en           <= lit_en;
      literal_value        <= lit_value;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      requests_sent++;
   endtask

   // Mostly named modes, sometimes one of the unused codes.
   task automatic send_random();
      logic [OP_WIDTH-1:0] operation;
      if ($urandom_range(99) < 88) begin
         operation = OP_WIDTH'($urandom_range(OP_XOR, OP_ADD));
      end else begin
         operation = OP_WIDTH'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end
      send_blend(operation, random_pixel(), random_pixel(), 1'b0, '0);
   endtask

   // Stop offering and wait for every outstanding response.
   task automatic wait_for_drain();
      req_chan.valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (expected_blends.size() != 0);
   endtask

   // Response side: random stalls, plus a long hold-off whenever the token moves.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Record expectations on request transfers and check response transfers.
   always @(posedge clock) begin
      pixel_type wanted;
      bit        moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            modes_seen[req_chan.operation] <= 1'b1;
            if (literal_en) begin
               expect_blend(literal_value);
            end else begin
               expect_blend(blend_predict(req_chan.operation, req_chan.base_value,
                                          req_chan.layer_value));
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (expected_blends.size() == 0) begin
               $error("blended_value: expected no response, actual %0d",
                      rsp_chan.blended_value);
               error_count++;
            end else begin
               wanted = expected_blends.pop_front();
               responses_checked++;
               if (rsp_chan.blended_value !== wanted) begin
                  $error("blended_value: expected %0d, actual %0d", wanted,
                         rsp_chan.blended_value);
                  error_count++;
               end
            end
         end
         // Watchdog on cycles without any transfer.
         if (moved) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $display("watchdog: no transfer in %0d cycles", WATCHDOG_LIMIT);
               $display("tb: failure");
               $finish;
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.operation   <= '0;
      req_chan.base_value  <= '0;
      req_chan.layer_value <= '0;
      literal_en           <= 1'b0;
      literal_value        <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table: extremes, every mode and the lowest and highest unused codes.
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_blend(directed_rows[i].operation, directed_rows[i].base_value,
                    directed_rows[i].layer_value, directed_rows[i].literal_en,
                    directed_rows[i].literal_value);
      end
      wait_for_drain();

      // Random requests under each idle pattern.
      for (int p = 0; p < N_PHASES; p++) begin
         sender_idle_pct    = sender_phase_pct[p];
         receiver_stall_pct = receiver_phase_pct[p];
         repeat (PHASE_ITEMS) send_random();
         wait_for_drain();
      end

      // Back-pressure: the receiver holds off while requests keep coming,
      // then the sender pauses until the pipeline has emptied.
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_token <= hold_token + 1;
      repeat (PRESSURE_ITEMS) send_random();
      wait_for_drain();

      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (expected_blends.size() != 0) begin
         $error("blended_value: %0d expected responses never arrived",
                expected_blends.size());
         error_count++;
      end

      $display("summary: %0d requests (%0d directed) and %0d responses checked, %0d of 16 codes",
               requests_sent, N_DIRECTED, responses_checked, $countones(modes_seen));
      $display("summary: idle on neither, sender, receiver and both sides, %0d-cycle hold-off",
               LONG_HOLD_CYCLES);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
